/* hdl/price_level_book_assert.svh */
// assertion macros for the price level book
// no dependencies, included by the modules that check their own logic
`ifndef PRICE_LEVEL_BOOK_ASSERT_SVH
`define PRICE_LEVEL_BOOK_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define PLB_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plb check failed");

// next-cycle implication under synchronous active-low reset
`define PLB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plb check failed");

`endif

/* hdl/plb_pkg.sv */
// shared types and constants for the price level book
// no dependencies
`default_nettype none

package plb_pkg;

    localparam int LEVELS_DEF      = 64;
    localparam int PRICE_BITS_DEF  = 32;
    localparam int VOLUME_BITS_DEF = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REDUCE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] KIND_ADDED   = 2'd0;
    localparam logic [1:0] KIND_UPDATED = 2'd1;
    localparam logic [1:0] KIND_DELETED = 2'd2;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_FULL      = 2'd1;
    localparam logic [1:0] ERR_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic        side;
        logic [31:0] price;
        logic [31:0] amount;
        logic [31:0] hidden_amount;
        logic [31:0] visible_amount;
        logic [31:0] remaining;
    } in_t;

    typedef struct packed {
        logic [1:0]  update_kind;
        logic [31:0] level_price;
        logic [31:0] total_volume;
        logic [31:0] hidden_volume;
        logic [31:0] visible_volume;
        logic [15:0] order_count;
        logic        is_top;
        logic [1:0]  error_code;
    } out_t;

    typedef struct packed {
        logic load;
        logic res_nop;
        logic find_rd;
        logic res_miss;
        logic fetch_rd;
        logic update;
        logic rescan_rd;
        logic rescan_commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_nop;
        logic miss;
        logic need_rescan;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* hdl/plb_ctrl.sv */
// controller state machine for the price level book
// depends on plb_pkg
`default_nettype none

module plb_ctrl #(
    parameter int LEVELS = plb_pkg::LEVELS_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  plb_pkg::sts_t    sts,
    output plb_pkg::cmd_t    cmd,
    output logic [$clog2(LEVELS)-1:0] scan_addr
);

    localparam int SLOT_W = $clog2(LEVELS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FIND, ST_FDRAIN, ST_FETCH, ST_UPDATE,
        ST_RESCAN, ST_RDRAIN, ST_RCOMMIT, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic last;

    assign last      = (cnt_reg == SLOT_W'(LEVELS - 1));
    assign scan_addr = cnt_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load    = 1'b1;
                    cmd.res_nop = sts.in_nop;
                    cnt_next    = '0;
                    state_next  = sts.in_nop ? ST_OUT : ST_FIND;
                end
            end
            ST_FIND: begin
                cmd.find_rd = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (last) state_next = ST_FDRAIN;
            end
            ST_FDRAIN: state_next = ST_FETCH;
            ST_FETCH: begin
                if (sts.miss) begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.fetch_rd = 1'b1;
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = sts.need_rescan ? ST_RESCAN : ST_OUT;
            end
            ST_RESCAN: begin
                cmd.rescan_rd = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (last) state_next = ST_RDRAIN;
            end
            ST_RDRAIN: state_next = ST_RCOMMIT;
            ST_RCOMMIT: begin
                cmd.rescan_commit = 1'b1;
                state_next        = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/plb_datapath.sv */
// datapath for the price level book: level memory, scan compare, best tracking
// depends on plb_pkg and price_level_book_assert.svh
`default_nettype none
`include "price_level_book_assert.svh"

module plb_datapath #(
    parameter int LEVELS      = plb_pkg::LEVELS_DEF,
    parameter int PRICE_BITS  = plb_pkg::PRICE_BITS_DEF,
    parameter int VOLUME_BITS = plb_pkg::VOLUME_BITS_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  plb_pkg::in_t     s_data,
    input  plb_pkg::cmd_t    cmd,
    input  wire [$clog2(LEVELS)-1:0] scan_addr,
    output plb_pkg::sts_t    sts,
    output logic             m_valid,
    input  wire              m_ready,
    output plb_pkg::out_t    m_data
);

    localparam int SLOT_W = $clog2(LEVELS);

    typedef struct packed {
        logic                   side;
        logic [PRICE_BITS-1:0]  price;
        logic [VOLUME_BITS-1:0] total;
        logic [VOLUME_BITS-1:0] hidden;
        logic [VOLUME_BITS-1:0] visible;
        logic [15:0]            orders;
    } entry_t;

    entry_t mem [LEVELS];
    logic [LEVELS-1:0] valid_reg;

    // captured item
    logic [1:0]             op_reg;
    logic                   side_reg;
    logic [PRICE_BITS-1:0]  price_reg;
    logic [VOLUME_BITS-1:0] amt_reg, hid_reg, vis_reg;
    logic                   rem_zero_reg;

    // read pipeline
    entry_t            rd_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_addr_reg;
    logic              ev_find_reg, ev_rs_reg;

    // lookup results
    logic              found_reg, free_found_reg;
    logic [SLOT_W-1:0] match_slot_reg, free_slot_reg;

    // rescan accumulators
    logic                  rs_found_reg;
    logic [SLOT_W-1:0]     rs_slot_reg;
    logic [PRICE_BITS-1:0] rs_price_reg;

    // best of book
    logic                  bid_present_reg, ask_present_reg;
    logic [SLOT_W-1:0]     bid_slot_reg, ask_slot_reg;
    logic [PRICE_BITS-1:0] bid_price_reg, ask_price_reg;

    logic          m_valid_reg;
    plb_pkg::out_t res_reg, m_data_reg;

    logic [63:0]       in_price_w, in_amt_w, in_hid_w, in_vis_w;
    logic [SLOT_W-1:0] tgt, rd_addr;
    logic              hit, free_hit, rs_better, rs_hit;
    logic              is_add, new_level, deleted, was_best;
    logic              bid_upd, ask_upd, top;
    entry_t            base, upd;
    logic [VOLUME_BITS:0] sum_t, sum_h, sum_v;
    plb_pkg::out_t     res_upd;

    assign in_price_w = 64'(s_data.price);
    assign in_amt_w   = 64'(s_data.amount);
    assign in_hid_w   = 64'(s_data.hidden_amount);
    assign in_vis_w   = 64'(s_data.visible_amount);

    assign tgt     = found_reg ? match_slot_reg : free_slot_reg;
    assign rd_addr = cmd.fetch_rd ? tgt : scan_addr;

    assign hit = ev_find_reg && rd_valid_reg && rd_reg.side == side_reg
                 && rd_reg.price == price_reg;
    assign free_hit  = ev_find_reg && !rd_valid_reg;
    assign rs_better = side_reg ? (rd_reg.price > rs_price_reg)
                                : (rd_reg.price < rs_price_reg);
    assign rs_hit = ev_rs_reg && rd_valid_reg && rd_reg.side == side_reg
                    && (!rs_found_reg || rs_better);

    assign is_add    = (op_reg == plb_pkg::OP_ADD);
    assign new_level = !found_reg;

    always_comb begin
        base = rd_reg;
        if (is_add && new_level) begin
            base = '0;
        end
        base.side  = side_reg;
        base.price = price_reg;
        sum_t = {1'b0, base.total}   + {1'b0, amt_reg};
        sum_h = {1'b0, base.hidden}  + {1'b0, hid_reg};
        sum_v = {1'b0, base.visible} + {1'b0, vis_reg};
        upd = base;
        if (is_add) begin
            upd.total   = sum_t[VOLUME_BITS] ? '1 : sum_t[VOLUME_BITS-1:0];
            upd.hidden  = sum_h[VOLUME_BITS] ? '1 : sum_h[VOLUME_BITS-1:0];
            upd.visible = sum_v[VOLUME_BITS] ? '1 : sum_v[VOLUME_BITS-1:0];
            if (base.orders != 16'hFFFF) upd.orders = base.orders + 16'd1;
        end else begin
            upd.total   = (amt_reg >= base.total)   ? '0 : base.total - amt_reg;
            upd.hidden  = (hid_reg >= base.hidden)  ? '0 : base.hidden - hid_reg;
            upd.visible = (vis_reg >= base.visible) ? '0 : base.visible - vis_reg;
            if ((op_reg == plb_pkg::OP_DELETE || rem_zero_reg) && base.orders != 16'd0) begin
                upd.orders = base.orders - 16'd1;
            end
        end
    end

    always_comb begin
        logic [63:0] p_w, t_w, h_w, v_w;
        p_w = 64'(price_reg);
        t_w = 64'(upd.total);
        h_w = 64'(upd.hidden);
        v_w = 64'(upd.visible);
        deleted  = !is_add && (upd.total == '0);
        was_best = side_reg ? (bid_present_reg && bid_slot_reg == tgt)
                            : (ask_present_reg && ask_slot_reg == tgt);
        bid_upd  = is_add && new_level && side_reg
                   && (!bid_present_reg || price_reg > bid_price_reg);
        ask_upd  = is_add && new_level && !side_reg
                   && (!ask_present_reg || price_reg < ask_price_reg);
        top = deleted || bid_upd || ask_upd || was_best;
        res_upd = '0;
        res_upd.update_kind    = deleted ? plb_pkg::KIND_DELETED
                               : (is_add && new_level) ? plb_pkg::KIND_ADDED
                               : plb_pkg::KIND_UPDATED;
        res_upd.level_price    = p_w[31:0];
        res_upd.total_volume   = t_w[31:0];
        res_upd.hidden_volume  = h_w[31:0];
        res_upd.visible_volume = v_w[31:0];
        res_upd.order_count    = upd.orders;
        res_upd.is_top         = top;
        res_upd.error_code     = plb_pkg::ERR_OK;
    end

    assign sts.in_nop      = (s_data.operation == plb_pkg::OP_NOP);
    assign sts.miss        = is_add ? (!found_reg && !free_found_reg) : !found_reg;
    assign sts.need_rescan = deleted && was_best;
    assign sts.out_free    = !m_valid_reg || m_ready;

    // memory read and write
    always_ff @(posedge aclk) begin
        rd_reg <= mem[rd_addr];
        if (cmd.update && !deleted) begin
            mem[tgt] <= upd;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        logic [63:0] ep;
        plb_pkg::out_t miss_res;
        ep = 64'(price_reg);
        miss_res = '0;
        miss_res.level_price = ep[31:0];
        miss_res.error_code  = is_add ? plb_pkg::ERR_FULL : plb_pkg::ERR_NOT_FOUND;
        rd_addr_reg  <= rd_addr;
        rd_valid_reg <= valid_reg[rd_addr];
        if (cmd.load) begin
            op_reg       <= s_data.operation;
            side_reg     <= s_data.side;
            price_reg    <= in_price_w[PRICE_BITS-1:0];
            amt_reg      <= in_amt_w[VOLUME_BITS-1:0];
            hid_reg      <= in_hid_w[VOLUME_BITS-1:0];
            vis_reg      <= in_vis_w[VOLUME_BITS-1:0];
            rem_zero_reg <= (s_data.remaining == 32'd0);
        end
        if (hit && !found_reg)       match_slot_reg <= rd_addr_reg;
        if (free_hit && !free_found_reg) free_slot_reg <= rd_addr_reg;
        if (cmd.update) begin
            rs_slot_reg  <= '0;
        end else if (rs_hit) begin
            rs_slot_reg  <= rd_addr_reg;
            rs_price_reg <= rd_reg.price;
        end
        if (cmd.res_nop) begin
            res_reg <= '0;
        end else if (cmd.res_miss) begin
            res_reg <= miss_res;
        end else if (cmd.update) begin
            res_reg <= res_upd;
        end
        if (cmd.out_load) m_data_reg <= res_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            ev_find_reg     <= 1'b0;
            ev_rs_reg       <= 1'b0;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            rs_found_reg    <= 1'b0;
            bid_present_reg <= 1'b0;
            ask_present_reg <= 1'b0;
            bid_slot_reg    <= '0;
            ask_slot_reg    <= '0;
            bid_price_reg   <= '0;
            ask_price_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            ev_find_reg <= cmd.find_rd;
            ev_rs_reg   <= cmd.rescan_rd;
            if (cmd.load) begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (hit)      found_reg      <= 1'b1;
                if (free_hit) free_found_reg <= 1'b1;
            end
            if (cmd.update) begin
                valid_reg[tgt] <= !deleted;
                rs_found_reg   <= 1'b0;
                if (bid_upd) begin
                    bid_present_reg <= 1'b1;
                    bid_slot_reg    <= tgt;
                    bid_price_reg   <= price_reg;
                end
                if (ask_upd) begin
                    ask_present_reg <= 1'b1;
                    ask_slot_reg    <= tgt;
                    ask_price_reg   <= price_reg;
                end
            end else if (rs_hit) begin
                rs_found_reg <= 1'b1;
            end
            if (cmd.rescan_commit) begin
                if (side_reg) begin
                    bid_present_reg <= rs_found_reg;
                    bid_slot_reg    <= rs_slot_reg;
                    bid_price_reg   <= rs_price_reg;
                end else begin
                    ask_present_reg <= rs_found_reg;
                    ask_slot_reg    <= rs_slot_reg;
                    ask_price_reg   <= rs_price_reg;
                end
            end
            if (cmd.out_load)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PLB_ASSERT_NEXT(a_out_load_valid, aclk, aresetn, cmd.out_load, m_valid_reg)
    `PLB_ASSERT_NOW(a_err_zero_volume, aclk, aresetn,
        m_valid_reg && m_data_reg.error_code != plb_pkg::ERR_OK,
        m_data_reg.total_volume == 32'd0 && m_data_reg.order_count == 16'd0)
    `PLB_ASSERT_NOW(a_deleted_top, aclk, aresetn,
        m_valid_reg && m_data_reg.update_kind == plb_pkg::KIND_DELETED,
        m_data_reg.is_top && m_data_reg.total_volume == 32'd0)

endmodule

`default_nettype wire

/* hdl/price_level_book.sv */
// sequence: accept, scan of every level slot, fetch, update, result; a deleted best level adds a
// rescan of every slot before the result; a miss skips fetch and update, an unused operation code
// goes straight to the result; one transaction at a time, through the single read port of the level
// memory that every lookup scans through; s_ready is high only while idle
// reset: synchronous active-low aresetn empties the table and clears best bid and ask
// top level of the price level book; depends on plb_pkg, plb_ctrl and plb_datapath
`default_nettype none

module price_level_book #(
    parameter int LEVELS      = plb_pkg::LEVELS_DEF,
    parameter int PRICE_BITS  = plb_pkg::PRICE_BITS_DEF,
    parameter int VOLUME_BITS = plb_pkg::VOLUME_BITS_DEF
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_valid,
    output logic          s_ready,
    input  plb_pkg::in_t  s_data,
    output logic          m_valid,
    input  wire           m_ready,
    output plb_pkg::out_t m_data
);

    // command and status between the sequencer and the datapath
    plb_pkg::cmd_t cmd;
    plb_pkg::sts_t sts;
    // scan counter, also the memory read address during lookup and rescan
    logic [$clog2(LEVELS)-1:0] scan_addr;

    // sequencer: lookup scan, fetch, update, optional rescan, result handoff
    plb_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    // level memory, best-of-book registers and the output register
    plb_datapath #(
        .LEVELS      (LEVELS),
        .PRICE_BITS  (PRICE_BITS),
        .VOLUME_BITS (VOLUME_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cmd       (cmd),
        .scan_addr (scan_addr),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

/* dv/tb_price_level_book.sv */
// testbench for the price level book: random and directed order traffic against a
// behavioral book model held in a scoreboard class; depends on plb_pkg and price_level_book
`timescale 1ns / 1ps
`default_nettype none

module tb_price_level_book;

    localparam int NLEV = 64;
    localparam int N_RANDOM = 1200;
    localparam int STALL_LIMIT = 4000;

    // book model plus queue of predicted level snapshots
    class level_book_scoreboard;
        bit        lv_valid[NLEV];
        bit        lv_side[NLEV];
        bit [31:0] lv_price[NLEV];
        bit [31:0] lv_total[NLEV];
        bit [31:0] lv_hidden[NLEV];
        bit [31:0] lv_visible[NLEV];
        bit [15:0] lv_orders[NLEV];
        int        bid_slot, ask_slot;
        bit        bid_present, ask_present;
        plb_pkg::out_t pending_snapshots[$];
        int        mismatches;

        function void queue_snapshot(plb_pkg::out_t r);
            pending_snapshots = {pending_snapshots, r};
        endfunction

        function bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
            bit [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function bit [31:0] sat_sub(bit [31:0] a, bit [31:0] b);
            return (b >= a) ? 32'd0 : a - b;
        endfunction

        function bit best_of(bit sd, int s);
            return sd ? (bid_present && bid_slot == s) : (ask_present && ask_slot == s);
        endfunction

        function int lookup(bit sd, bit [31:0] p);
            for (int i = 0; i < NLEV; i++)
                if (lv_valid[i] && lv_side[i] == sd && lv_price[i] == p) return i;
            return -1;
        endfunction

        function int level_count();
            int n;
            n = 0;
            foreach (lv_valid[i]) n += lv_valid[i];
            return n;
        endfunction

        function void rescan(bit sd);
            bit found;
            int slot;
            found = 0;
            slot = 0;
            for (int i = 0; i < NLEV; i++)
                if (lv_valid[i] && lv_side[i] == sd && (!found ||
                    (sd ? lv_price[i] > lv_price[slot] : lv_price[i] < lv_price[slot]))) begin
                    found = 1;
                    slot = i;
                end
            if (sd) begin
                bid_present = found;
                bid_slot = slot;
            end else begin
                ask_present = found;
                ask_slot = slot;
            end
        endfunction

        function void note_order(plb_pkg::in_t t);
            plb_pkg::out_t r;
            int s;
            r = '0;
            if (t.operation == plb_pkg::OP_NOP) begin
                queue_snapshot(r);
                return;
            end
            s = lookup(t.side, t.price);
            if (t.operation == plb_pkg::OP_ADD) begin
                r.update_kind = plb_pkg::KIND_UPDATED;
                if (s < 0) begin
                    for (int i = 0; i < NLEV; i++)
                        if (!lv_valid[i]) begin
                            s = i;
                            break;
                        end
                    if (s < 0) begin
                        r = '0;
                        r.level_price = t.price;
                        r.error_code = plb_pkg::ERR_FULL;
                        queue_snapshot(r);
                        return;
                    end
                    lv_valid[s] = 1;
                    lv_side[s] = t.side;
                    lv_price[s] = t.price;
                    lv_total[s] = 0;
                    lv_hidden[s] = 0;
                    lv_visible[s] = 0;
                    lv_orders[s] = 0;
                    if (t.side) begin
                        if (!bid_present || t.price > lv_price[bid_slot]) begin
                            bid_present = 1;
                            bid_slot = s;
                        end
                    end else if (!ask_present || t.price < lv_price[ask_slot]) begin
                        ask_present = 1;
                        ask_slot = s;
                    end
                    r.update_kind = plb_pkg::KIND_ADDED;
                end
                lv_total[s] = sat_add(lv_total[s], t.amount);
                lv_hidden[s] = sat_add(lv_hidden[s], t.hidden_amount);
                lv_visible[s] = sat_add(lv_visible[s], t.visible_amount);
                if (lv_orders[s] != 16'hFFFF) lv_orders[s]++;
                r.is_top = best_of(t.side, s);
            end else begin
                if (s < 0) begin
                    r.level_price = t.price;
                    r.error_code = plb_pkg::ERR_NOT_FOUND;
                    queue_snapshot(r);
                    return;
                end
                lv_total[s] = sat_sub(lv_total[s], t.amount);
                lv_hidden[s] = sat_sub(lv_hidden[s], t.hidden_amount);
                lv_visible[s] = sat_sub(lv_visible[s], t.visible_amount);
                if ((t.operation == plb_pkg::OP_DELETE || t.remaining == 0) && lv_orders[s] != 0)
                    lv_orders[s]--;
                r.update_kind = plb_pkg::KIND_UPDATED;
                if (lv_total[s] == 0) begin
                    bit was_best;
                    was_best = best_of(t.side, s);
                    lv_valid[s] = 0;
                    if (was_best) rescan(t.side);
                    r.update_kind = plb_pkg::KIND_DELETED;
                    r.is_top = 1;
                end else begin
                    r.is_top = best_of(t.side, s);
                end
            end
            r.level_price = lv_price[s];
            r.total_volume = lv_total[s];
            r.hidden_volume = lv_hidden[s];
            r.visible_volume = lv_visible[s];
            r.order_count = lv_orders[s];
            queue_snapshot(r);
        endfunction

        function void check_snapshot(plb_pkg::out_t got);
            plb_pkg::out_t exp_r;
            if (pending_snapshots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = pending_snapshots.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    plb_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    plb_pkg::out_t m_data;

    level_book_scoreboard book_sb = new();
    int  idle_cycles = 0;
    bit  hold_off = 0;

    price_level_book DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // price pool kept narrow so that levels are hit again and again
    function automatic bit [31:0] pick_price();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return 32'd1000 + $urandom_range(0, 40);
        endcase
    endfunction

    function automatic bit [31:0] pick_amount();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom();
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // one transaction into the book, with a random gap first
    task automatic send_order(input logic [1:0] op, input logic sd, input logic [31:0] p,
                              input logic [31:0] a, input logic [31:0] h,
                              input logic [31:0] v, input logic [31:0] rem);
        plb_pkg::in_t t;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        t.operation = op;
        t.side = sd;
        t.price = p;
        t.amount = a;
        t.hidden_amount = h;
        t.visible_amount = v;
        t.remaining = rem;
        s_valid <= 1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        book_sb.note_order(t);
    endtask

    task automatic send_random();
        logic [1:0] op;
        logic sd;
        logic [31:0] p, a;
        int r;
        r = $urandom_range(0, 99);
        sd = $urandom_range(0, 1);
        a = pick_amount();
        if (r < 50) op = plb_pkg::OP_ADD;
        else if (r < 75) op = plb_pkg::OP_REDUCE;
        else if (r < 97) op = plb_pkg::OP_DELETE;
        else op = plb_pkg::OP_NOP;
        // most reduces and deletes aim at a resting level
        if (op != plb_pkg::OP_ADD && op != plb_pkg::OP_NOP && $urandom_range(0, 4) != 0) begin
            int s;
            s = $urandom_range(0, NLEV - 1);
            for (int k = 0; k < NLEV; k++)
                if (book_sb.lv_valid[(s + k) % NLEV]) begin
                    s = (s + k) % NLEV;
                    break;
                end
            p = book_sb.lv_valid[s] ? book_sb.lv_price[s] : pick_price();
            sd = book_sb.lv_valid[s] ? book_sb.lv_side[s] : sd;
            if ($urandom_range(0, 2) == 0) a = book_sb.lv_total[s];
        end else begin
            p = pick_price();
        end
        send_order(op, sd, p, a, pick_amount(), pick_amount(),
                   $urandom_range(0, 1) ? 32'd0 : $urandom());
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int wait_n;
        @(posedge aresetn);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (hold_off) begin
                wait_n = 600;
                hold_off = 0;
            end
            if (wait_n > 0) begin
                m_ready <= 0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            book_sb.check_snapshot(m_data);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else if (aresetn && !hold_off) idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb_price_level_book: FAIL");
            $finish;
        end
    end

    initial begin
        int drain;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: misses on empty book, nop, extremes, saturation
        send_order(plb_pkg::OP_REDUCE, 1, 32'd5, 32'd1, 0, 0, 0);
        send_order(plb_pkg::OP_DELETE, 0, 32'hFFFF_FFFF, 32'd1, 0, 0, 0);
        send_order(plb_pkg::OP_NOP, 1, 32'hFFFF_FFFF, '1, '1, '1, '1);
        send_order(plb_pkg::OP_ADD, 1, 32'd0, 32'd0, 0, 0, 0);
        send_order(plb_pkg::OP_ADD, 1, 32'hFFFF_FFFF, '1, '1, '1, '1);
        send_order(plb_pkg::OP_ADD, 1, 32'hFFFF_FFFF, 32'd10, 32'd3, 32'd7, 0);
        send_order(plb_pkg::OP_ADD, 0, 32'hFFFF_FFFF, 32'd50, 32'd20, 32'd30, 0);
        send_order(plb_pkg::OP_ADD, 0, 32'd0, 32'd40, 32'd10, 32'd30, 0);
        send_order(plb_pkg::OP_ADD, 0, 32'd7, 32'd40, 32'd10, 32'd30, 0);
        send_order(plb_pkg::OP_REDUCE, 0, 32'd7, 32'd5, 32'd100, 32'd1, 32'd9);
        send_order(plb_pkg::OP_REDUCE, 0, 32'd7, 32'd5, 32'd0, 32'd1, 32'd0);
        send_order(plb_pkg::OP_REDUCE, 0, 32'd0, '1, '1, '1, '1);
        send_order(plb_pkg::OP_DELETE, 1, 32'hFFFF_FFFF, '1, 0, 0, 0);
        send_order(plb_pkg::OP_DELETE, 1, 32'd0, 32'd0, 0, 0, 0);
        send_order(plb_pkg::OP_DELETE, 1, 32'd0, 32'd1, 0, 0, 0);
        // fill the table; two levels still rest, so the last two adds and one more give the table-full error
        for (int i = 0; i < NLEV; i++)
            send_order(plb_pkg::OP_ADD, i[0], 32'd2000 + i, 32'd3, 32'd1, 32'd2, 0);
        send_order(plb_pkg::OP_ADD, 1, 32'd9999, 32'd1, 0, 0, 0);
        // empty it again so the random part starts from a thin book
        while (book_sb.level_count() > 0) begin
            for (int i = 0; i < NLEV; i++)
                if (book_sb.lv_valid[i]) begin
                    send_order(plb_pkg::OP_DELETE, book_sb.lv_side[i], book_sb.lv_price[i],
                               book_sb.lv_total[i], 0, 0, 0);
                    break;
                end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) hold_off = 1;
            send_random();
        end
        s_valid <= 0;

        drain = 0;
        while (book_sb.pending_snapshots.size() != 0 && drain < 200000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (2 * NLEV + 20) @(posedge aclk);
        if (book_sb.mismatches == 0 && book_sb.pending_snapshots.size() == 0)
            $display("tb_price_level_book: PASS");
        else
            $display("tb_price_level_book: FAIL");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/plb_pkg.sv
hdl/plb_ctrl.sv
hdl/plb_datapath.sv
hdl/price_level_book.sv
dv/tb_price_level_book.sv
